// File: rtl/rvd_pkg.sv
// Package with the opcodes, operation codes, status codes and result type of the decoder.
`timescale 1ns / 1ps

package rvd_pkg;

  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_FENCE  = 7'b0001111;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_SLT  = 3'b010;
  localparam logic [2:0] F3_SLTU = 3'b011;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;
  localparam logic [2:0] F3_WORD = 3'b010;

  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [2:0] F3_BLT  = 3'b100;
  localparam logic [2:0] F3_BGE  = 3'b101;
  localparam logic [2:0] F3_BLTU = 3'b110;
  localparam logic [2:0] F3_BGEU = 3'b111;

  typedef enum logic [4:0] {
    OP_NONE, OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
    OP_OR, OP_AND, OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
    OP_SLLI, OP_SRLI, OP_SRAI, OP_LUI, OP_AUIPC, OP_BEQ, OP_BNE, OP_BLT,
    OP_BGE, OP_BLTU, OP_BGEU, OP_JAL, OP_JALR, OP_LW, OP_SW
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IGNORED = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_e;

  typedef struct packed {
    op_e         operation;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
    status_e     status;
  } rvd_result_t;

  function automatic logic [31:0] sext12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

endpackage

// File: rtl/rvd_decode.sv
// Combinational decode of one RV32I instruction word into operation, registers and immediate.
`timescale 1ns / 1ps

module rvd_decode import rvd_pkg::*; (
  input  logic [31:0]  instr_i,
  output rvd_result_t  result_o
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rd;
  logic [4:0] r1;
  logic [4:0] r2;

  assign opc = instr_i[6:0];
  assign rd  = instr_i[11:7];
  assign f3  = instr_i[14:12];
  assign r1  = instr_i[19:15];
  assign r2  = instr_i[24:20];
  assign f7  = instr_i[31:25];

  always_comb begin
    // Everything is zero unless the format uses it; unknown opcodes stay illegal.
    result_o.operation = OP_NONE;
    result_o.dest_reg  = '0;
    result_o.src1_reg  = '0;
    result_o.src2_reg  = '0;
    result_o.immediate = '0;
    result_o.status    = ST_ILLEGAL;
    case (opc)
      OPC_OP: begin
        result_o.status   = ST_OK;
        result_o.dest_reg = rd;
        result_o.src1_reg = r1;
        result_o.src2_reg = r2;
        case (f3)
          F3_ADD: begin
            if (f7 == F7_ALT) begin
              result_o.operation = OP_SUB;
            end else if (f7 == F7_BASE) begin
              result_o.operation = OP_ADD;
            end else begin
              result_o.status   = ST_ILLEGAL;
              result_o.dest_reg = '0;
              result_o.src1_reg = '0;
              result_o.src2_reg = '0;
            end
          end
          F3_SLL:  result_o.operation = OP_SLL;
          F3_SLT:  result_o.operation = OP_SLT;
          F3_SLTU: result_o.operation = OP_SLTU;
          F3_XOR:  result_o.operation = OP_XOR;
          F3_SR:   result_o.operation = (f7 == F7_ALT) ? OP_SRA : OP_SRL;
          F3_OR:   result_o.operation = OP_OR;
          F3_AND:  result_o.operation = OP_AND;
          default: result_o.operation = OP_NONE;
        endcase
      end
      OPC_OPIMM: begin
        result_o.status    = ST_OK;
        result_o.dest_reg  = rd;
        result_o.src1_reg  = r1;
        result_o.immediate = sext12(instr_i[31:20]);
        case (f3)
          F3_ADD:  result_o.operation = OP_ADDI;
          F3_SLT:  result_o.operation = OP_SLTI;
          F3_SLTU: result_o.operation = OP_SLTIU;
          F3_XOR:  result_o.operation = OP_XORI;
          F3_OR:   result_o.operation = OP_ORI;
          F3_AND:  result_o.operation = OP_ANDI;
          F3_SLL: begin
            result_o.operation = OP_SLLI;
            result_o.immediate = {27'd0, r2};
          end
          F3_SR: begin
            result_o.operation = (f7 == F7_ALT) ? OP_SRAI : OP_SRLI;
            result_o.immediate = {27'd0, r2};
          end
          default: result_o.operation = OP_NONE;
        endcase
      end
      OPC_LUI: begin
        result_o.status    = ST_OK;
        result_o.operation = OP_LUI;
        result_o.dest_reg  = rd;
        result_o.immediate = {12'd0, instr_i[31:12]};
      end
      OPC_AUIPC: begin
        result_o.status    = ST_OK;
        result_o.operation = OP_AUIPC;
        result_o.dest_reg  = rd;
        result_o.immediate = {12'd0, instr_i[31:12]};
      end
      OPC_BRANCH: begin
        result_o.status    = ST_OK;
        result_o.src1_reg  = r1;
        result_o.src2_reg  = r2;
        result_o.immediate = {{19{instr_i[31]}}, instr_i[31], instr_i[7],
                              instr_i[30:25], instr_i[11:8], 1'b0};
        case (f3)
          F3_BEQ:  result_o.operation = OP_BEQ;
          F3_BNE:  result_o.operation = OP_BNE;
          F3_BLT:  result_o.operation = OP_BLT;
          F3_BGE:  result_o.operation = OP_BGE;
          F3_BLTU: result_o.operation = OP_BLTU;
          F3_BGEU: result_o.operation = OP_BGEU;
          default: begin
            // The two unused branch encodings are illegal and carry nothing.
            result_o.status    = ST_ILLEGAL;
            result_o.src1_reg  = '0;
            result_o.src2_reg  = '0;
            result_o.immediate = '0;
          end
        endcase
      end
      OPC_JAL: begin
        result_o.status    = ST_OK;
        result_o.operation = OP_JAL;
        result_o.dest_reg  = rd;
        result_o.immediate = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12],
                              instr_i[20], instr_i[30:21], 1'b0};
      end
      OPC_JALR: begin
        result_o.status    = ST_OK;
        result_o.operation = OP_JALR;
        result_o.dest_reg  = rd;
        result_o.src1_reg  = r1;
        result_o.immediate = sext12(instr_i[31:20]);
      end
      OPC_LOAD: begin
        if (f3 == F3_WORD) begin
          result_o.status    = ST_OK;
          result_o.operation = OP_LW;
          result_o.dest_reg  = rd;
          result_o.src1_reg  = r1;
          result_o.immediate = sext12(instr_i[31:20]);
        end else begin
          result_o.status = ST_IGNORED;
        end
      end
      OPC_STORE: begin
        if (f3 == F3_WORD) begin
          result_o.status    = ST_OK;
          result_o.operation = OP_SW;
          result_o.src1_reg  = r1;
          result_o.src2_reg  = r2;
          result_o.immediate = sext12({f7, rd});
        end else begin
          result_o.status = ST_IGNORED;
        end
      end
      OPC_FENCE, OPC_SYSTEM: begin
        result_o.status = ST_IGNORED;
      end
      default: begin
        result_o.status = ST_ILLEGAL;
      end
    endcase
  end

endmodule

// File: rtl/rv32i_instruction_decoder_unit.sv
// Top level of the RV32I instruction decoder: input register, decode logic and result register.
`timescale 1ns / 1ps

// The decoder takes one instruction word per clock: a request is accepted whenever start_i is
// high and busy_o is low, and busy_o is high during reset and in the first cycle after reset is
// released. Each request gives exactly one result, shown for one cycle with done_o high; the
// receiver cannot hold it off, and since the path is a plain two-register pipeline with no stall,
// nothing is ever lost. The latency is set by the input register and the result register around
// the decode logic. Status tells a decoded word from an ignored one (fences, system instructions,
// loads and stores other than word size) and from an illegal one.
module rv32i_instruction_decoder_unit import rvd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [31:0]        instruction_i,
  output logic               done_o,
  output logic [4:0]         operation_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic signed [31:0] immediate_o,
  output logic [1:0]         status_o
);

  logic        ready_q;
  logic        valid_q;
  logic        done_q;
  logic [31:0] instr_q;
  rvd_result_t dec;
  rvd_result_t result_q;
  logic        accept;

  assign accept = start_i && ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      ready_q <= 1'b1;
      valid_q <= accept;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instruction_i;
    end
    if (valid_q) begin
      result_q <= dec;
    end
  end

  rvd_decode u_decode (
    .instr_i  (instr_q),
    .result_o (dec)
  );

  assign busy_o      = !ready_q;
  assign done_o      = done_q;
  assign operation_o = result_q.operation;
  assign dest_reg_o  = result_q.dest_reg;
  assign src1_reg_o  = result_q.src1_reg;
  assign src2_reg_o  = result_q.src2_reg;
  assign immediate_o = signed'(result_q.immediate);
  assign status_o    = result_q.status;

  // Every accepted request leaves the pipeline through the input register and the result register.
  a_request_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted request gave no result two cycles later");

  // A result never appears without an earlier accepted request.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result without a request");

  // Ignored and illegal words carry no operation, registers or immediate.
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |->
      (operation_o == OP_NONE && dest_reg_o == 5'd0 && src1_reg_o == 5'd0 &&
       src2_reg_o == 5'd0 && immediate_o == 32'sd0))
    else $error("rejected word carries decoded fields");

  // Branch offsets are even and branches write no register.
  a_branch_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && operation_o >= OP_BEQ && operation_o <= OP_BGEU) |->
      (immediate_o[0] == 1'b0 && dest_reg_o == 5'd0))
    else $error("malformed branch result");

  // Upper immediates are the raw twenty bits, never sign-extended.
  a_upper_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (operation_o == OP_LUI || operation_o == OP_AUIPC)) |->
      (immediate_o[31:20] == 12'd0))
    else $error("upper immediate has high bits set");

endmodule
